// ===== hdl/qisd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qisd_pkg
// shared types, register codes and fixed-point helpers for the ins derivative
// ----------------------------------------------------------------------------
package qisd_pkg;

  localparam int unsigned AddrW = 4;

  localparam logic [1:0] REG_GRAVITY     = 2'd0;
  localparam logic [1:0] REG_ORIENT_PRES = 2'd1;
  localparam logic [1:0] REG_VEL_PRES    = 2'd2;

  localparam logic signed [15:0] GravityReset = -16'sd10042;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               vel_xy_active;
    logic               vel_z_active;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] dquat_w;
    logic signed [31:0] dquat_x;
    logic signed [31:0] dquat_y;
    logic signed [31:0] dquat_z;
    logic signed [31:0] dvel_x;
    logic signed [31:0] dvel_y;
    logic signed [31:0] dvel_z;
    logic               quat_valid;
    logic               vel_xy_valid;
    logic               vel_z_valid;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] gravity;
    logic               orientation_present;
    logic               velocity_present;
  } cfg_t;

  // clamp a wide signed value to the 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    logic signed [52:0] hi;
    logic signed [52:0] lo;
    hi = 53'sd2147483647;
    lo = -53'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== hdl/qisd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qisd_in_if / qisd_out_if
// valid/ready channels carrying the input and result words
// ----------------------------------------------------------------------------
interface qisd_in_if;
  logic               valid;
  logic               ready;
  qisd_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qisd_out_if;
  logic                valid;
  logic                ready;
  qisd_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/quaternion_ins_state_derivative_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_ins_state_derivative_core
// quaternion rate and world-frame acceleration for a strapdown ins
// ----------------------------------------------------------------------------
// in_if carries one word per sample: attitude quaternion, body rate, body
// acceleration and the two velocity activity flags. out_if returns one word
// per input word: the quaternion derivative, the rotated acceleration with
// gravity on z, and a valid flag per group. groups that are off read zero.
// the apb port holds gravity (0x0), orientation present (0x4) and velocity
// present (0x8); write it only while the block is empty.
// a result passes through the four register stages of the multiply and sum
// pipeline (the first loads when its input word is accepted) before it shows
// on out_if; one word enters every cycle while out_if is not stalled. all
// stages advance together: when out_if is stalled the whole pipeline holds
// and in_if.ready drops, so no word is lost or repeated. reset empties the
// pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
module quaternion_ins_state_derivative_core (
  input  logic                         clk,
  input  logic                         rst_n,
  qisd_in_if.sink                      in_if,
  qisd_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qisd_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  qisd_pkg::cfg_t cfg_r;
  logic           en;
  logic           wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity             <= qisd_pkg::GravityReset;
      cfg_r.orientation_present <= 1'b1;
      cfg_r.velocity_present    <= 1'b1;
    end else if (wr) begin
      case (paddr[3:2])
        qisd_pkg::REG_GRAVITY:     cfg_r.gravity             <= pwdata[15:0];
        qisd_pkg::REG_ORIENT_PRES: cfg_r.orientation_present <= pwdata[0];
        qisd_pkg::REG_VEL_PRES:    cfg_r.velocity_present    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      qisd_pkg::REG_GRAVITY:     prdata = 32'(cfg_r.gravity);
      qisd_pkg::REG_ORIENT_PRES: prdata = {31'd0, cfg_r.orientation_present};
      qisd_pkg::REG_VEL_PRES:    prdata = {31'd0, cfg_r.velocity_present};
      default:                   prdata = 32'd0;
    endcase
  end

  // pipeline moves whenever the output slot is free or being taken
  assign en          = ~out_if.valid | out_if.ready;
  assign in_if.ready = en;

  qisd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_if.valid),
    .in_word   (in_if.data),
    .cfg       (cfg_r),
    .out_valid (out_if.valid),
    .out_word  (out_if.data)
  );

endmodule

// ===== hdl/qisd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qisd_datapath
// four-stage pipeline: products, matrix and quaternion rate, matrix times
// acceleration, final sums with rounding and saturation
// ----------------------------------------------------------------------------
module qisd_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  qisd_pkg::in_word_t  in_word,
  input  qisd_pkg::cfg_t      cfg,
  output logic                out_valid,
  output qisd_pkg::out_word_t out_word
);

  // stage 1: raw products
  logic               v1_r;
  logic               qon1_r, xy1_r, z1_r;
  logic signed [31:0] pr1_r [12];
  logic signed [31:0] pq1_r [10];
  logic signed [15:0] a1_r [3];

  // stage 2: quaternion derivative done, rotation matrix formed
  logic               v2_r;
  logic               qon2_r, xy2_r, z2_r;
  logic signed [31:0] dq2_r [4];
  logic signed [33:0] m2_r [9];
  logic signed [15:0] a2_r [3];

  // stage 3: matrix times acceleration
  logic               v3_r;
  logic               qon3_r, xy3_r, z3_r;
  logic signed [31:0] dq3_r [4];
  logic signed [49:0] p3_r [9];

  // stage 4: output
  logic                v4_r;
  qisd_pkg::out_word_t o4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      qon1_r <= cfg.orientation_present;
      xy1_r  <= cfg.velocity_present & in_word.vel_xy_active;
      z1_r   <= cfg.velocity_present & in_word.vel_z_active;
      // rate products: rx*qw rx*qx rx*qy rx*qz, then ry, then rz
      pr1_r[0]  <= in_word.rate_x * in_word.quat_w;
      pr1_r[1]  <= in_word.rate_x * in_word.quat_x;
      pr1_r[2]  <= in_word.rate_x * in_word.quat_y;
      pr1_r[3]  <= in_word.rate_x * in_word.quat_z;
      pr1_r[4]  <= in_word.rate_y * in_word.quat_w;
      pr1_r[5]  <= in_word.rate_y * in_word.quat_x;
      pr1_r[6]  <= in_word.rate_y * in_word.quat_y;
      pr1_r[7]  <= in_word.rate_y * in_word.quat_z;
      pr1_r[8]  <= in_word.rate_z * in_word.quat_w;
      pr1_r[9]  <= in_word.rate_z * in_word.quat_x;
      pr1_r[10] <= in_word.rate_z * in_word.quat_y;
      pr1_r[11] <= in_word.rate_z * in_word.quat_z;
      // ww xx yy zz xy xz yz wx wy wz
      pq1_r[0] <= in_word.quat_w * in_word.quat_w;
      pq1_r[1] <= in_word.quat_x * in_word.quat_x;
      pq1_r[2] <= in_word.quat_y * in_word.quat_y;
      pq1_r[3] <= in_word.quat_z * in_word.quat_z;
      pq1_r[4] <= in_word.quat_x * in_word.quat_y;
      pq1_r[5] <= in_word.quat_x * in_word.quat_z;
      pq1_r[6] <= in_word.quat_y * in_word.quat_z;
      pq1_r[7] <= in_word.quat_w * in_word.quat_x;
      pq1_r[8] <= in_word.quat_w * in_word.quat_y;
      pq1_r[9] <= in_word.quat_w * in_word.quat_z;
      a1_r[0] <= in_word.accel_x;
      a1_r[1] <= in_word.accel_y;
      a1_r[2] <= in_word.accel_z;
    end
  end

  // stage 2 logic
  logic signed [33:0] s2_nxt [4];
  logic signed [31:0] dq2_nxt [4];
  logic signed [33:0] m2_nxt [9];
  logic signed [33:0] e [10];

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      e[i] = (i < 4) ? 34'(pq1_r[i]) : (34'(pq1_r[i]) <<< 1);
    end
    s2_nxt[0] = -34'(pr1_r[1]) - 34'(pr1_r[6]) - 34'(pr1_r[11]);
    s2_nxt[1] =  34'(pr1_r[0]) + 34'(pr1_r[10]) - 34'(pr1_r[7]);
    s2_nxt[2] =  34'(pr1_r[4]) - 34'(pr1_r[9]) + 34'(pr1_r[3]);
    s2_nxt[3] =  34'(pr1_r[8]) + 34'(pr1_r[5]) - 34'(pr1_r[2]);
    for (int i = 0; i < 4; i++) begin
      // halve, round half up
      dq2_nxt[i] = qon1_r ? qisd_pkg::sat32(53'((s2_nxt[i] + 34'sd1) >>> 1)) : 32'sd0;
    end
    m2_nxt[0] = e[0] + e[1] - e[2] - e[3];
    m2_nxt[1] = e[4] - e[9];
    m2_nxt[2] = e[5] + e[8];
    m2_nxt[3] = e[4] + e[9];
    m2_nxt[4] = e[0] - e[1] + e[2] - e[3];
    m2_nxt[5] = e[6] - e[7];
    m2_nxt[6] = e[5] - e[8];
    m2_nxt[7] = e[6] + e[7];
    m2_nxt[8] = e[0] - e[1] - e[2] + e[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qon2_r <= qon1_r;
      xy2_r  <= xy1_r;
      z2_r   <= z1_r;
      dq2_r  <= dq2_nxt;
      m2_r   <= m2_nxt;
      a2_r   <= a1_r;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      qon3_r <= qon2_r;
      xy3_r  <= xy2_r;
      z3_r   <= z2_r;
      dq3_r  <= dq2_r;
      for (int i = 0; i < 9; i++) begin
        p3_r[i] <= m2_r[i] * a2_r[i % 3];
      end
    end
  end

  // stage 4 logic
  logic signed [52:0]  sv_nxt [3];
  logic signed [52:0]  rv_nxt [3];
  qisd_pkg::out_word_t o4_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv_nxt[i] = 53'(p3_r[3*i]) + 53'(p3_r[3*i+1]) + 53'(p3_r[3*i+2]);
    end
    sv_nxt[2] = sv_nxt[2] + (53'(cfg.gravity) <<< 28);
    for (int i = 0; i < 3; i++) begin
      rv_nxt[i] = (sv_nxt[i] + (53'sd1 <<< 27)) >>> 28;
    end
    o4_nxt.dquat_w      = dq3_r[0];
    o4_nxt.dquat_x      = dq3_r[1];
    o4_nxt.dquat_y      = dq3_r[2];
    o4_nxt.dquat_z      = dq3_r[3];
    o4_nxt.dvel_x       = xy3_r ? qisd_pkg::sat32(rv_nxt[0]) : 32'sd0;
    o4_nxt.dvel_y       = xy3_r ? qisd_pkg::sat32(rv_nxt[1]) : 32'sd0;
    o4_nxt.dvel_z       = z3_r  ? qisd_pkg::sat32(rv_nxt[2]) : 32'sd0;
    o4_nxt.quat_valid   = qon3_r;
    o4_nxt.vel_xy_valid = xy3_r;
    o4_nxt.vel_z_valid  = z3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o4_r <= o4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_word  = o4_r;

endmodule

// ===== hdl/qisd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qisd_checker
// port-level checks on the ins derivative core
// ----------------------------------------------------------------------------
module qisd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input qisd_pkg::out_word_t out_word
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is stalled");

  a_quat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.quat_valid |-> out_word.dquat_w == 0 &&
      out_word.dquat_x == 0 && out_word.dquat_y == 0 && out_word.dquat_z == 0)
    else $error("quaternion derivative not cleared when off");

  a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.vel_xy_valid |-> out_word.dvel_x == 0 &&
      out_word.dvel_y == 0)
    else $error("horizontal velocity derivative not cleared when off");

endmodule

bind quaternion_ins_state_derivative_core qisd_checker u_qisd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_word  (out_if.data)
);
